FILE: rtl/source_code_token_lexer_macros.svh
// Assertion macros shared by the token lexer RTL.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef SOURCE_CODE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_CODE_TOKEN_LEXER_MACROS_SVH

// same-cycle implication
`define SCTL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sctl: same-cycle check failed");

// next-cycle implication
`define SCTL_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sctl: next-cycle check failed");

`endif

FILE: rtl/sctl_pkg.sv
// Types, constants and character classes for the token lexer.
// No dependencies; used by sctl_decode and source_code_token_lexer.
package sctl_pkg;

	localparam int MaxResults = 5;
	localparam int CntW       = $clog2(MaxResults + 1);

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_LINE    = 3'd3,
		MODE_BLOCK   = 3'd4,
		MODE_STRING  = 3'd5,
		MODE_CHAR    = 3'd6
	} lex_mode_t;

	localparam logic [1:0] KIND_IDENT  = 2'd0;
	localparam logic [1:0] KIND_NUMBER = 2'd1;
	localparam logic [1:0] KIND_SYMBOL = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// words emitted for string and character literals
	localparam logic [2:0][7:0] STR_WORD = {"r", "t", "s"};
	localparam logic [2:0][7:0] CHR_WORD = {"r", "h", "c"};

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [7:0] char_code;
		logic       token_start;
		logic       last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic       start;
	} res_t;

	typedef struct packed {
		lex_mode_t mode;
		logic      slash_held;
		logic      star_seen;
		logic      escape_pending;
	} lex_state_t;

	typedef struct packed {
		res_t [MaxResults-1:0] res;
		logic [CntW-1:0]       count;
	} decode_t;

	localparam lex_state_t LexReset = '{
		mode: MODE_BETWEEN, slash_held: 1'b0, star_seen: 1'b0, escape_pending: 1'b0
	};
	localparam res_t SlashSym = '{kind: KIND_SYMBOL, code: CH_SLASH, start: 1'b1};
	localparam res_t EndTok   = '{kind: KIND_END, code: 8'h00, start: 1'b1};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

endpackage

FILE: rtl/sctl_decode.sv
// Per-byte lexer decision: next state and the list of tokens one byte causes.
// Purely combinational; depends on sctl_pkg.
module sctl_decode (
	input  sctl_pkg::lex_state_t cur,
	input  sctl_pkg::in_beat_t   beat,
	output sctl_pkg::lex_state_t nxt,
	output sctl_pkg::decode_t    dec
);
	import sctl_pkg::*;

	always_comb begin
		lex_state_t            s;
		logic [7:0]            b;
		logic [7:0]            c;
		logic [7:0]            closer;
		logic                  pre;
		logic                  do_plain;
		logic                  post;
		res_t [2:0]            w;
		logic [1:0]            wn;
		res_t [MaxResults-1:0] r;
		logic [CntW-1:0]       n;

		s        = cur;
		b        = beat.char_byte;
		c        = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		closer   = CH_DQUOTE;
		pre      = 1'b0;
		do_plain = 1'b0;
		w        = '0;
		wn       = 2'd0;

		unique case (cur.mode)
			MODE_LINE: begin
				if (b == CH_NL) s.mode = MODE_BETWEEN;
			end
			MODE_BLOCK: begin
				if (cur.star_seen && b == CH_SLASH) begin
					s.mode      = MODE_BETWEEN;
					s.star_seen = 1'b0;
				end else begin
					s.star_seen = (b == CH_STAR);
				end
			end
			MODE_STRING, MODE_CHAR: begin
				closer = (cur.mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
				if (cur.escape_pending) s.escape_pending = 1'b0;
				else if (b == CH_BSLASH) s.escape_pending = 1'b1;
				else if (b == closer) s.mode = MODE_BETWEEN;
			end
			default: begin
				// unused mode code falls back to between tokens
				if (cur.mode != MODE_IDENT && cur.mode != MODE_NUMBER) s.mode = MODE_BETWEEN;
				if (cur.slash_held) begin
					s.slash_held = 1'b0;
					if (b == CH_SLASH) begin
						s.mode = MODE_LINE;
					end else if (b == CH_STAR) begin
						s.mode      = MODE_BLOCK;
						s.star_seen = 1'b0;
					end else begin
						pre      = 1'b1;
						s.mode   = MODE_BETWEEN;
						do_plain = 1'b1;
					end
				end else begin
					do_plain = 1'b1;
				end
			end
		endcase

		if (do_plain) begin
			if (c == CH_SLASH) begin
				s.slash_held = 1'b1;
				s.mode       = MODE_BETWEEN;
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				for (int k = 0; k < 3; k++) begin
					w[k] = '{kind: KIND_IDENT,
						code: (c == CH_DQUOTE) ? STR_WORD[k] : CHR_WORD[k],
						start: (k == 0)};
				end
				wn               = 2'd3;
				s.mode           = (c == CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
				s.escape_pending = 1'b0;
			end else if (is_space(c)) begin
				s.mode = MODE_BETWEEN;
			end else if (s.mode == MODE_IDENT &&
				(is_alpha(c) || is_digit(c) || c == CH_USCORE)) begin
				w[0] = '{kind: KIND_IDENT, code: c, start: 1'b0};
				wn   = 2'd1;
			end else if (s.mode == MODE_NUMBER &&
				(is_alpha(c) || is_digit(c) || c == CH_DOT)) begin
				wn = 2'd0;
			end else if (is_alpha(c) || c == CH_USCORE) begin
				w[0]   = '{kind: KIND_IDENT, code: c, start: 1'b1};
				wn     = 2'd1;
				s.mode = MODE_IDENT;
			end else if (is_digit(c)) begin
				w[0]   = '{kind: KIND_NUMBER, code: 8'h00, start: 1'b1};
				wn     = 2'd1;
				s.mode = MODE_NUMBER;
			end else begin
				w[0]   = '{kind: KIND_SYMBOL, code: c, start: 1'b1};
				wn     = 2'd1;
				s.mode = MODE_BETWEEN;
			end
		end

		post = beat.end_of_text && s.slash_held;
		if (beat.end_of_text) s = LexReset;

		// pack the results in emission order
		r = '0;
		n = '0;
		if (pre) begin
			r[n] = SlashSym;
			n    = n + CntW'(1);
		end
		for (int k = 0; k < 3; k++) begin
			if (k < int'(wn) && n < CntW'(MaxResults)) begin
				r[n] = w[k];
				n    = n + CntW'(1);
			end
		end
		if (post && n < CntW'(MaxResults)) begin
			r[n] = SlashSym;
			n    = n + CntW'(1);
		end
		if (beat.end_of_text && n < CntW'(MaxResults)) begin
			r[n] = EndTok;
			n    = n + CntW'(1);
		end

		nxt       = s;
		dec.res   = r;
		dec.count = n;
	end

endmodule

FILE: rtl/source_code_token_lexer.sv
// Top level of the streaming source lexer: input register, decode, result buffer.
// Depends on sctl_pkg, sctl_decode and source_code_token_lexer_macros.svh.
//
// Source bytes arrive on the byte channel (byte_valid/byte_stall/byte_data),
// one byte per beat; end_of_text marks the last byte of a text. Tokens leave on
// the tok channel (tok_valid/tok_stall/tok_data), one result per beat.
// An accepted byte waits in the input register until the result buffer is free,
// is then decoded against the lexer state and its results (zero to five) are
// loaded into the result buffer, from which the first result is offered.
// While tok_stall is low the result buffer drains one beat per cycle, and bytes
// giving zero or one result sustain one per cycle.
// While the buffer drains, the input register still takes one more byte.
// When tok_stall is high the offered result holds and the input side stalls once
// the input register is full. Reset empties both registers and puts the lexer
// between tokens with no held slash, no pending star and no pending escape.
// End of text flushes a held slash, appends an end marker and clears the state.
module source_code_token_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  sctl_pkg::in_beat_t  byte_data,
	output logic                tok_valid,
	input  logic                tok_stall,
	output sctl_pkg::out_beat_t tok_data
);
	import sctl_pkg::*;
	`include "source_code_token_lexer_macros.svh"

	logic            valid_s1;
	in_beat_t        byte_s1;
	lex_state_t      state_q;
	lex_state_t      state_nxt;
	decode_t         dec;
	res_t            ents_q [MaxResults];
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] idx_q;
	logic            take;
	logic            drain_done;
	logic            buf_free;
	logic            s1_move;
	logic            accept;

	sctl_decode u_decode (
		.cur  (state_q),
		.beat (byte_s1),
		.nxt  (state_nxt),
		.dec  (dec)
	);

	assign tok_valid  = (cnt_q != '0);
	assign take       = tok_valid && !tok_stall;
	assign drain_done = take && (idx_q == cnt_q - CntW'(1));
	assign buf_free   = !tok_valid || drain_done;
	assign s1_move    = valid_s1 && buf_free;
	assign byte_stall = valid_s1 && !buf_free;
	assign accept     = byte_valid && !byte_stall;

	assign tok_data.token_kind  = ents_q[idx_q].kind;
	assign tok_data.char_code   = ents_q[idx_q].code;
	assign tok_data.token_start = ents_q[idx_q].start;
	assign tok_data.last_of_run = (idx_q == cnt_q - CntW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) byte_s1 <= byte_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LexReset;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (s1_move) begin
			state_q <= state_nxt;
			cnt_q   <= dec.count;
			idx_q   <= '0;
		end else if (drain_done) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			for (int k = 0; k < MaxResults; k++) ents_q[k] <= dec.res[k];
		end
	end

	`SCTL_ASSERT_IMP(a_idx_in_range, tok_valid, idx_q < cnt_q)
	`SCTL_ASSERT_IMP(a_cnt_bounded, 1'b1, cnt_q <= CntW'(MaxResults))
	`SCTL_ASSERT_IMP(a_stall_needs_full, byte_stall, valid_s1 && tok_valid)
	`SCTL_ASSERT_NXT(a_end_clears_state, s1_move && byte_s1.end_of_text, state_q == LexReset)
	`SCTL_ASSERT_NXT(a_end_marker_last, s1_move && byte_s1.end_of_text,
		tok_valid && ents_q[cnt_q - CntW'(1)].kind == KIND_END)

endmodule

FILE: tb/tb.sv
// Self-checking bench for source_code_token_lexer: directed table, then random source texts.
// Depends on sctl_pkg for the beat structs, lexer modes, token kinds and character codes.
// Expected tokens come from the lexer predictor here or typed table rows, checked in order.
module tb;
	import sctl_pkg::*;

	localparam int IdleLimit = 3000;
	localparam int ItemTarget = 400;

	localparam string IdHead  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string IdBody  = "abcxyzABCXYZ_0123456789";
	localparam string Digits  = "0123456789";
	localparam string NumBody = "0123456789.xXeEfFaL";
	localparam string Punct   = "+-*=<>!&|^%~?:;,.(){}[]#@";

	typedef struct packed {
		in_beat_t  beat;
		logic      typed;
		out_beat_t want;
	} lex_row_t;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_beat_t  byte_data;
	logic      tok_valid;
	logic      tok_stall;
	out_beat_t tok_data;

	// predictor state
	lex_mode_t lx_mode;
	logic      lx_slash;
	logic      lx_star;
	logic      lx_esc;

	out_beat_t run_q[$];    // tokens caused by the byte being predicted
	out_beat_t token_q[$];  // tokens still awaited from the block
	in_beat_t  src_q[$];
	lex_row_t  dir_rows[$];
	out_beat_t want;
	int        errors;
	int        tok_seen;
	int        idle_cycles;
	int        calm_left;

	source_code_token_lexer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_data   (tok_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic void lex_reset();
		lx_mode  = MODE_BETWEEN;
		lx_slash = 1'b0;
		lx_star  = 1'b0;
		lx_esc   = 1'b0;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void put_tok(logic [1:0] k, logic [7:0] c, logic s);
		out_beat_t t;
		t.token_kind  = k;
		t.char_code   = c;
		t.token_start = s;
		t.last_of_run = 1'b0;
		if (run_q.size() < MaxResults)
			run_q.insert(run_q.size(), t);
	endfunction

	function automatic void put_word(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		put_tok(KIND_IDENT, a, 1'b1);
		put_tok(KIND_IDENT, b, 1'b0);
		put_tok(KIND_IDENT, c, 1'b0);
	endfunction

	function automatic void lex_plain(logic [7:0] c);
		if (c == CH_SLASH) begin
			lx_slash = 1'b1;
			lx_mode  = MODE_BETWEEN;
		end else if (c == CH_DQUOTE) begin
			put_word("s", "t", "r");
			lx_mode = MODE_STRING;
			lx_esc  = 1'b0;
		end else if (c == CH_SQUOTE) begin
			put_word("c", "h", "r");
			lx_mode = MODE_CHAR;
			lx_esc  = 1'b0;
		end else if (is_blank(c)) begin
			lx_mode = MODE_BETWEEN;
		end else if (lx_mode == MODE_IDENT && (is_letter(c) || is_numeral(c) || c == CH_USCORE)) begin
			put_tok(KIND_IDENT, c, 1'b0);
		end else if (lx_mode == MODE_NUMBER && (is_letter(c) || is_numeral(c) || c == CH_DOT)) begin
			// number runs on silently
		end else if (is_letter(c) || c == CH_USCORE) begin
			put_tok(KIND_IDENT, c, 1'b1);
			lx_mode = MODE_IDENT;
		end else if (is_numeral(c)) begin
			put_tok(KIND_NUMBER, 8'h00, 1'b1);
			lx_mode = MODE_NUMBER;
		end else begin
			put_tok(KIND_SYMBOL, c, 1'b1);
			lx_mode = MODE_BETWEEN;
		end
	endfunction

	function automatic void lex_literal(logic [7:0] b, logic [7:0] closer);
		if (lx_esc)
			lx_esc = 1'b0;
		else if (b == CH_BSLASH)
			lx_esc = 1'b1;
		else if (b == closer)
			lx_mode = MODE_BETWEEN;
	endfunction

	function automatic void lex_byte(in_beat_t beat);
		logic [7:0] b;
		logic [7:0] c;
		b = beat.char_byte;
		c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		run_q.delete();
		case (lx_mode)
			MODE_LINE: begin
				if (b == CH_NL)
					lx_mode = MODE_BETWEEN;
			end
			MODE_BLOCK: begin
				if (lx_star && b == CH_SLASH) begin
					lx_mode = MODE_BETWEEN;
					lx_star = 1'b0;
				end else begin
					lx_star = (b == CH_STAR);
				end
			end
			MODE_STRING: lex_literal(b, CH_DQUOTE);
			MODE_CHAR:   lex_literal(b, CH_SQUOTE);
			default: begin
				if (lx_mode > MODE_NUMBER)
					lx_mode = MODE_BETWEEN;
				if (lx_slash) begin
					lx_slash = 1'b0;
					if (b == CH_SLASH) begin
						lx_mode = MODE_LINE;
					end else if (b == CH_STAR) begin
						lx_mode = MODE_BLOCK;
						lx_star = 1'b0;
					end else begin
						put_tok(KIND_SYMBOL, CH_SLASH, 1'b1);
						lx_mode = MODE_BETWEEN;
						lex_plain(c);
					end
				end else begin
					lex_plain(c);
				end
			end
		endcase
		if (beat.end_of_text) begin
			if (lx_slash)
				put_tok(KIND_SYMBOL, CH_SLASH, 1'b1);
			put_tok(KIND_END, 8'h00, 1'b1);
			lex_reset();
		end
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last_of_run = 1'b1;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic void add_row(logic [7:0] c, logic eot, logic typed = 1'b0,
			out_beat_t w = '0);
		lex_row_t r;
		r.beat.char_byte   = c;
		r.beat.end_of_text = eot;
		r.typed            = typed;
		r.want             = w;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void push_ch(logic [7:0] c);
		in_beat_t b;
		b.char_byte   = c;
		b.end_of_text = 1'b0;
		src_q.insert(src_q.size(), b);
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] any_symbol();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return pick(Punct);
		else if (r == 2)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 8));
	endfunction

	function automatic void add_literal(logic [7:0] closer);
		logic [7:0] b;
		push_ch(closer);
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 4) == 0) begin
				push_ch(CH_BSLASH);
				push_ch(8'($urandom_range(0, 255)));
			end else begin
				do b = 8'($urandom_range(0, 255));
				while (b == closer || b == CH_BSLASH);
				push_ch(b);
			end
		end
		push_ch(closer);
	endfunction

	// one source text of mostly well-formed pieces, closed by an end marker
	function automatic void build_text();
		logic [7:0] b;
		int         r;
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					push_ch(pick(IdHead));
					repeat ($urandom_range(0, 5)) push_ch(pick(IdBody));
				end
				2: begin
					push_ch(pick(Digits));
					repeat ($urandom_range(0, 4)) push_ch(pick(NumBody));
				end
				3: add_literal(CH_DQUOTE);
				4: add_literal(CH_SQUOTE);
				5: begin
					push_ch(CH_SLASH);
					push_ch(CH_SLASH);
					repeat ($urandom_range(0, 6)) begin
						do b = 8'($urandom_range(0, 255));
						while (b == CH_NL);
						push_ch(b);
					end
					push_ch(CH_NL);
				end
				6: begin
					push_ch(CH_SLASH);
					push_ch(CH_STAR);
					repeat ($urandom_range(0, 6)) begin
						r = $urandom_range(0, 5);
						push_ch(r < 2 ? CH_STAR : r == 2 ? CH_SLASH : 8'($urandom_range(0, 255)));
					end
					push_ch(CH_STAR);
					push_ch(CH_SLASH);
				end
				7: push_ch(any_symbol());
				default: begin
					repeat ($urandom_range(1, 2))
						push_ch($urandom_range(0, 5) == 5 ? 8'h20 : 8'($urandom_range(9, 13)));
				end
			endcase
		end
		// now and then end on an open literal, an open block comment or a held slash
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: push_ch(CH_DQUOTE);
				1: push_ch(CH_SQUOTE);
				2: begin
					push_ch(CH_SLASH);
					push_ch(CH_STAR);
				end
				default: push_ch(CH_SLASH);
			endcase
			if (src_q[src_q.size() - 1].char_byte != CH_SLASH)
				repeat ($urandom_range(0, 3)) push_ch(pick(IdBody));
		end
		src_q[src_q.size() - 1].end_of_text = 1'b1;
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if (r < 3)
			calm_left = $urandom_range(20, 50);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_beat(in_beat_t b, logic typed, out_beat_t w);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_data  <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		lex_byte(b);
		if (typed)
			token_q.insert(token_q.size(), w);
		else
			foreach (run_q[i]) token_q.insert(token_q.size(), run_q[i]);
	endtask

	// ---------------- token receiver ----------------

	initial begin
		int  hold_left;
		int  free_left;
		int  r;
		logic squeezed;
		hold_left = 0;
		free_left = 0;
		squeezed  = 1'b0;
		tok_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && free_left == 0) begin
				r = $urandom_range(0, 99);
				if (!squeezed && tok_seen >= 120) begin
					// long hold-off so the block fills and stalls its byte side
					squeezed  = 1'b1;
					hold_left = 80;
				end else if (r < 8) begin
					free_left = $urandom_range(20, 60);
				end else if (r < 12) begin
					hold_left = $urandom_range(10, 30);
				end else if (r < 45) begin
					hold_left = $urandom_range(1, 3);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_stall <= 1'b1;
			end else begin
				if (free_left > 0)
					free_left--;
				tok_stall <= 1'b0;
			end
		end
	end

	// ---------------- checking ----------------

	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			tok_seen++;
			if (token_q.size() == 0) begin
				$display("%0t: unexpected token kind %0d code %02h start %0b last %0b", $time,
					tok_data.token_kind, tok_data.char_code, tok_data.token_start,
					tok_data.last_of_run);
				errors++;
			end else begin
				want = token_q.pop_front();
				if (tok_data.token_kind !== want.token_kind || tok_data.char_code !== want.char_code
						|| tok_data.token_start !== want.token_start
						|| tok_data.last_of_run !== want.last_of_run) begin
					$display("%0t: token mismatch: expected kind %0d code %02h start %0b last %0b",
						$time, want.token_kind, want.char_code, want.token_start, want.last_of_run);
					$display("%0t:                 got kind %0d code %02h start %0b last %0b",
						$time, tok_data.token_kind, tok_data.char_code, tok_data.token_start,
						tok_data.last_of_run);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (tok_valid && !tok_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int sent;
		errors      = 0;
		tok_seen    = 0;
		idle_cycles = 0;
		calm_left   = 0;
		sent        = 0;
		byte_valid  = 1'b0;
		byte_data   = '0;
		arst_n      = 1'b0;
		lex_reset();

		// identifier, blank, number ended by a slash, slash flushed by a symbol
		add_row("A", 1'b0, 1'b1, '{KIND_IDENT, "a", 1'b1, 1'b1});
		add_row("Z", 1'b0, 1'b1, '{KIND_IDENT, "z", 1'b0, 1'b1});
		add_row(8'h20, 1'b0);
		add_row("0", 1'b0, 1'b1, '{KIND_NUMBER, 8'h00, 1'b1, 1'b1});
		add_row(CH_SLASH, 1'b0);
		add_row("+", 1'b0);
		// line comment, then slash star slash which must leave the block open
		add_row(CH_SLASH, 1'b0);
		add_row(CH_SLASH, 1'b0);
		add_row(CH_NL, 1'b0);
		add_row(CH_SLASH, 1'b0);
		add_row(CH_STAR, 1'b0);
		add_row(CH_SLASH, 1'b0);
		add_row(CH_STAR, 1'b0);
		add_row(CH_SLASH, 1'b0);
		// string with an escaped quote, empty char literal, bytes FF and 00 as symbols
		add_row(CH_DQUOTE, 1'b0);
		add_row(CH_BSLASH, 1'b0);
		add_row(CH_DQUOTE, 1'b0);
		add_row(CH_DQUOTE, 1'b0);
		add_row(CH_SQUOTE, 1'b0);
		add_row(CH_SQUOTE, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, '{KIND_SYMBOL, 8'hFF, 1'b1, 1'b1});
		add_row(8'h00, 1'b0, 1'b1, '{KIND_SYMBOL, 8'h00, 1'b1, 1'b1});
		// held slash flushed at end of text
		add_row(CH_SLASH, 1'b1);
		// block comment still open at end of text
		add_row(CH_SLASH, 1'b0);
		add_row(CH_STAR, 1'b1, 1'b1, '{KIND_END, 8'h00, 1'b1, 1'b1});
		// slash then an unterminated string on the last byte: five results
		add_row(CH_SLASH, 1'b0);
		add_row(CH_DQUOTE, 1'b1);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		while (sent < ItemTarget) begin
			src_q.delete();
			if ($urandom_range(0, 4) == 0) begin
				// raw bytes, end marker now and then
				repeat ($urandom_range(1, 12)) begin
					push_ch(8'($urandom_range(0, 255)));
					src_q[src_q.size() - 1].end_of_text = ($urandom_range(0, 15) == 0);
				end
			end else begin
				build_text();
			end
			foreach (src_q[i]) begin
				send_beat(src_q[i], 1'b0, '0);
				sent++;
			end
		end
		@(negedge clk);
		byte_valid <= 1'b0;

		while (token_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sctl_pkg.sv
rtl/sctl_decode.sv
rtl/source_code_token_lexer.sv
tb/tb.sv
